// ----- rtl/core/periodic_event_scheduler_unit_assert.svh -----
// Assertion helpers for the scheduler. Every check is sampled on the rising
// clock edge and is switched off while reset is asserted.
`ifndef PERIODIC_EVENT_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_EVENT_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define PES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ----- rtl/core/pes_pkg.sv -----
package pes_pkg;

    // Field widths.
    localparam int FUNC_W    = 2;
    localparam int TIME_W    = 32;
    localparam int SLOT_W    = 2;
    localparam int DUR_W     = 24;
    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 32;
    localparam int TOTAL_W   = 48;
    localparam int IVL_W     = 16;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Slot limits: the register map covers four slots.
    localparam int MAX_SLOTS     = 4;
    localparam int DEFAULT_SLOTS = 4;

    // Run queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FILL_W     = 3;

    // Millisecond to microsecond scaling.
    localparam int MS_W     = 10;
    localparam int IVL_US_W = IVL_W + MS_W;
    localparam logic [MS_W-1:0]  MS_TO_US  = 10'd1000;
    localparam logic [DUR_W-1:0] MIN_START = 24'd100000;

    // Function codes of an input word.
    localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PROCESS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE    = 2'd2;

    // Kind codes of a result word.
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATS    = 2'd2;

    // Configuration register indexes; intervals sit below the mask.
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_queue;
        logic start_step;
        logic scan_step;
        logic pop;
        logic report;
        logic emit_none;
    } pes_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic any_active;
    } pes_status_t;

endpackage

// ----- rtl/core/pes_controller.sv -----
module pes_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pes_pkg::FUNC_W-1:0]  func,
    input  pes_pkg::pes_status_t        status,
    output pes_pkg::pes_cmd_t           cmd,
    output logic                        busy
);
    import pes_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_POP    = 5'b01000,
        ST_REPORT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequencing of the three item types.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (func)
                        FUNC_START:
                        begin
                            cmd.clear_queue = 1'b1;
                            if (status.any_active)
                                state_next = ST_START;
                            else
                                cmd.emit_none = 1'b1;
                        end
                        FUNC_PROCESS: state_next = ST_SCAN;
                        FUNC_DONE:    state_next = ST_REPORT;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START:
            begin
                cmd.start_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_POP;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/core/pes_datapath.sv -----
module pes_datapath #(
    parameter int LIVE = pes_pkg::MAX_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pes_pkg::pes_cmd_t              cmd,
    output pes_pkg::pes_status_t           status,
    input  logic [pes_pkg::TIME_W-1:0]     now_us,
    input  logic [pes_pkg::SLOT_W-1:0]     slot,
    input  logic [pes_pkg::DUR_W-1:0]      duration_us,
    input  logic                           cfg_we,
    input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pes_pkg::IVL_W-1:0]      cfg_data,
    output logic                           strobe,
    output logic [pes_pkg::KIND_W-1:0]     kind,
    output logic [pes_pkg::SLOT_W-1:0]     slot_out,
    output logic [pes_pkg::COUNT_W-1:0]    run_count,
    output logic [pes_pkg::TOTAL_W-1:0]    total_time,
    output logic [pes_pkg::DUR_W-1:0]      shortest,
    output logic [pes_pkg::DUR_W-1:0]      longest,
    output logic                           last
);
    import pes_pkg::*;

    localparam int IW = (LIVE > 1) ? $clog2(LIVE) : 1;

    // Configuration registers.
    logic [IVL_W-1:0]   interval_reg [LIVE];
    logic [MASK_W-1:0]  active_reg;

    // Per-slot state.
    logic               queued_reg [LIVE];
    logic [TIME_W-1:0]  due_reg    [LIVE];
    logic [COUNT_W-1:0] count_reg  [LIVE];
    logic [TOTAL_W-1:0] total_reg  [LIVE];
    logic [DUR_W-1:0]   min_reg    [LIVE];
    logic [DUR_W-1:0]   max_reg    [LIVE];

    // Run queue.
    logic [SLOT_W-1:0]  fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] head_reg;
    logic [FILL_W-1:0]  fill_reg;

    // Latched item and scan index.
    logic [TIME_W-1:0]  now_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [IW-1:0]      idx_reg;

    // Result register.
    logic               strobe_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [COUNT_W-1:0] run_count_reg;
    logic [TOTAL_W-1:0] total_out_reg;
    logic [DUR_W-1:0]   shortest_reg;
    logic [DUR_W-1:0]   longest_reg;
    logic               last_reg;

    logic [LIVE-1:0]     live_active;
    logic [TIME_W-1:0]   diff;
    logic                is_due;
    logic                enq;
    logic [FIFO_AW-1:0]  tail;
    logic                pop_ok;
    logic                pop_empty;
    logic [IW-1:0]       pop_slot;
    logic                disp_en;
    logic [IW-1:0]       disp_slot;
    logic [COUNT_W-1:0]  count_next;
    logic [IVL_US_W-1:0] ivl_us;
    logic [TIME_W-1:0]   due_new;
    logic                last_start;
    logic                in_range;
    logic [IW-1:0]       rep_slot;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  total_new;
    logic [DUR_W-1:0]    min_new;
    logic [DUR_W-1:0]    max_new;
    logic                rep_en;
    logic                emit_none;

    assign live_active = active_reg[LIVE-1:0];

    // Status toward the controller.
    assign status.scan_last  = (idx_reg == IW'(LIVE - 1));
    assign status.any_active = |live_active;

    // Due test on the scanned slot: signed difference not above zero.
    assign diff   = due_reg[idx_reg] - now_reg;
    assign is_due = (diff == '0) || diff[TIME_W-1];
    assign enq    = cmd.scan_step && live_active[idx_reg] && !queued_reg[idx_reg]
                    && is_due && !fill_reg[FILL_W-1];
    assign tail   = head_reg + fill_reg[FIFO_AW-1:0];

    // Queue front.
    assign pop_ok    = cmd.pop && (fill_reg != '0);
    assign pop_empty = cmd.pop && (fill_reg == '0);
    assign pop_slot  = fifo_mem[head_reg][IW-1:0];

    // Dispatch of one slot: count, reschedule.
    assign disp_en    = (cmd.start_step && live_active[idx_reg]) || pop_ok;
    assign disp_slot  = cmd.start_step ? idx_reg : pop_slot;
    assign count_next = (&count_reg[disp_slot]) ? count_reg[disp_slot]
                                                : count_reg[disp_slot] + 1'b1;
    assign ivl_us     = IVL_US_W'(interval_reg[disp_slot]) * IVL_US_W'(MS_TO_US);
    assign due_new    = now_reg + TIME_W'(ivl_us);

    // A start dispatch is the last one if no higher live slot is active.
    always_comb
    begin
        last_start = 1'b1;
        for (int j = 0; j < LIVE; j++)
        begin
            if ((IW'(j) > idx_reg) && live_active[j])
                last_start = 1'b0;
        end
    end

    // Statistics update of a done report.
    assign in_range  = ({1'b0, slot_reg} < (SLOT_W + 1)'(LIVE));
    assign rep_slot  = slot_reg[IW-1:0];
    assign rep_en    = cmd.report && in_range;
    assign sum       = {1'b0, total_reg[rep_slot]} + (TOTAL_W + 1)'(dur_reg);
    assign total_new = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    assign min_new   = (dur_reg < min_reg[rep_slot]) ? dur_reg : min_reg[rep_slot];
    assign max_new   = (dur_reg > max_reg[rep_slot]) ? dur_reg : max_reg[rep_slot];

    assign emit_none = cmd.emit_none || pop_empty;

    // Control and per-slot state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIVE; i++)
            begin
                interval_reg[i] <= '0;
                queued_reg[i]   <= 1'b0;
                due_reg[i]      <= '0;
                count_reg[i]    <= '0;
                total_reg[i]    <= '0;
                min_reg[i]      <= MIN_START;
                max_reg[i]      <= '0;
            end
            active_reg <= '0;
            head_reg   <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ACTIVE_MASK)
                    active_reg <= cfg_data[MASK_W-1:0];
                else if ((cfg_index >= REG_INTERVAL_0)
                         && (cfg_index < CFG_IDX_W'(LIVE)))
                    interval_reg[cfg_index[IW-1:0]] <= cfg_data;
            end

            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.start_step || cmd.scan_step)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.clear_queue)
            begin
                for (int i = 0; i < LIVE; i++)
                    queued_reg[i] <= 1'b0;
                head_reg <= '0;
                fill_reg <= '0;
            end

            if (enq)
            begin
                queued_reg[idx_reg] <= 1'b1;
                fill_reg            <= fill_reg + 1'b1;
            end

            if (pop_ok)
            begin
                head_reg <= head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end

            if (disp_en)
            begin
                count_reg[disp_slot]  <= count_next;
                queued_reg[disp_slot] <= 1'b0;
                due_reg[disp_slot]    <= due_new;
            end

            if (rep_en)
            begin
                total_reg[rep_slot] <= total_new;
                min_reg[rep_slot]   <= min_new;
                max_reg[rep_slot]   <= max_new;
            end

            strobe_reg <= disp_en || emit_none || cmd.report;
        end
    end

    // Latched item fields and queue entries.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= now_us;
            slot_reg <= slot;
            dur_reg  <= duration_us;
        end
        if (enq)
            fifo_mem[tail] <= SLOT_W'(idx_reg);
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (emit_none)
        begin
            kind_reg      <= KIND_NONE;
            slot_out_reg  <= '0;
            run_count_reg <= '0;
            total_out_reg <= '0;
            shortest_reg  <= '0;
            longest_reg   <= '0;
            last_reg      <= 1'b1;
        end
        else if (disp_en)
        begin
            kind_reg      <= KIND_DISPATCH;
            slot_out_reg  <= SLOT_W'(disp_slot);
            run_count_reg <= count_next;
            total_out_reg <= total_reg[disp_slot];
            shortest_reg  <= min_reg[disp_slot];
            longest_reg   <= max_reg[disp_slot];
            last_reg      <= cmd.start_step ? last_start : 1'b1;
        end
        else if (cmd.report)
        begin
            kind_reg      <= KIND_STATS;
            slot_out_reg  <= slot_reg;
            run_count_reg <= in_range ? count_reg[rep_slot] : '0;
            total_out_reg <= in_range ? total_new : '0;
            shortest_reg  <= in_range ? min_new : '0;
            longest_reg   <= in_range ? max_new : '0;
            last_reg      <= 1'b1;
        end
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign slot_out   = slot_out_reg;
    assign run_count  = run_count_reg;
    assign total_time = total_out_reg;
    assign shortest   = shortest_reg;
    assign longest    = longest_reg;
    assign last       = last_reg;

endmodule

// ----- rtl/core/periodic_event_scheduler_unit.sv -----
// Periodic scheduler; L = min(SLOTS, 4) slots, scanned one per cycle by the sequencer.
// Start: one word per active slot, or a single none word if no slot is active.
// Process: scan slots and queue due ones, then dispatch one popped slot, or none if empty.
// Done report: one stats word per item. Every word appears in the cycle after the step that made it.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset (async, active low) clears config, queue and statistics; shortest starts at 100000.
`include "periodic_event_scheduler_unit_assert.svh"

module periodic_event_scheduler_unit #(
    parameter int SLOTS = pes_pkg::DEFAULT_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pes_pkg::FUNC_W-1:0]     func,
    input  logic [pes_pkg::TIME_W-1:0]     now_us,
    input  logic [pes_pkg::SLOT_W-1:0]     slot,
    input  logic [pes_pkg::DUR_W-1:0]      duration_us,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pes_pkg::IVL_W-1:0]      cfg_data,
    output logic                           strobe,
    output logic [pes_pkg::KIND_W-1:0]     kind,
    output logic [pes_pkg::SLOT_W-1:0]     slot_out,
    output logic [pes_pkg::COUNT_W-1:0]    run_count,
    output logic [pes_pkg::TOTAL_W-1:0]    total_time,
    output logic [pes_pkg::DUR_W-1:0]      shortest,
    output logic [pes_pkg::DUR_W-1:0]      longest,
    output logic                           last
);
    import pes_pkg::*;

    localparam int LIVE = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;

    pes_cmd_t    cmd;
    pes_status_t status;
    logic        cfg_we;

    // Register writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    pes_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pes_datapath #(
        .LIVE (LIVE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .now_us      (now_us),
        .slot        (slot),
        .duration_us (duration_us),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .kind        (kind),
        .slot_out    (slot_out),
        .run_count   (run_count),
        .total_time  (total_time),
        .shortest    (shortest),
        .longest     (longest),
        .last        (last)
    );

    // Only start dispatches can be followed by more words of the same item.
    `PES_ASSERT_SAME(a_not_last_is_dispatch, clk, rst_n, strobe && !last,
        kind == KIND_DISPATCH)

    // A word that reports nothing dispatched carries no statistics and ends its item.
    `PES_ASSERT_SAME(a_none_is_empty, clk, rst_n, strobe && (kind == KIND_NONE),
        (run_count == '0) && (total_time == '0) && last)

    // A process item always scans before it pops.
    `PES_ASSERT_NEXT(a_process_scans, clk, rst_n,
        start && !busy && (func == FUNC_PROCESS), busy)

    // A done report produces its word only after the update cycle.
    `PES_ASSERT_NEXT(a_report_delay, clk, rst_n,
        start && !busy && (func == FUNC_DONE), !strobe)

endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pes_pkg::*;

    // Function code that the block ignores, and a register index with no register behind it.
    localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;

    // One command word as handed to the block.
    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now;
        logic [SLOT_W-1:0] slot;
        logic [DUR_W-1:0]  dur;
        bit                drain_first;
    } command_t;

    // One result word as strobed by the block.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] runs;
        logic [TOTAL_W-1:0] total;
        logic [DUR_W-1:0]   lo;
        logic [DUR_W-1:0]   hi;
        logic               last;
    } report_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [FUNC_W-1:0]    func = '0;
    logic [TIME_W-1:0]    now_us = '0;
    logic [SLOT_W-1:0]    slot = '0;
    logic [DUR_W-1:0]     duration_us = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IVL_W-1:0]     cfg_data = '0;
    logic                 strobe;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot_out;
    logic [COUNT_W-1:0]   run_count;
    logic [TOTAL_W-1:0]   total_time;
    logic [DUR_W-1:0]     shortest;
    logic [DUR_W-1:0]     longest;
    logic                 last;

    periodic_event_scheduler_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .now_us(now_us),
        .slot(slot),
        .duration_us(duration_us),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .kind(kind),
        .slot_out(slot_out),
        .run_count(run_count),
        .total_time(total_time),
        .shortest(shortest),
        .longest(longest),
        .last(last)
    );

    command_t command_queue[$];
    report_t  awaited_reports[$];
    command_t word_on_port;
    int       idle_left = 0;
    bit       gaps_on = 1'b1;
    int       mismatches = 0;
    int       cycle_count = 0;

    // Scheduler state as the bench expects it to evolve.
    logic [IVL_W-1:0]   interval_ms [MAX_SLOTS];
    logic [MASK_W-1:0]  enabled_slots;
    bit                 in_queue [MAX_SLOTS];
    logic [TIME_W-1:0]  next_due [MAX_SLOTS];
    logic [SLOT_W-1:0]  run_line [FIFO_DEPTH];
    logic [FIFO_AW-1:0] line_head;
    logic [FILL_W-1:0]  line_fill;
    logic [COUNT_W-1:0] runs [MAX_SLOTS];
    logic [TOTAL_W-1:0] busy_total [MAX_SLOTS];
    logic [DUR_W-1:0]   busy_min [MAX_SLOTS];
    logic [DUR_W-1:0]   busy_max [MAX_SLOTS];

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_schedule();
        enabled_slots = '0;
        line_head = '0;
        line_fill = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            interval_ms[i] = '0;
            in_queue[i] = 1'b0;
            next_due[i] = '0;
            runs[i] = '0;
            busy_total[i] = '0;
            busy_min[i] = MIN_START;
            busy_max[i] = '0;
        end
        for (int i = 0; i < FIFO_DEPTH; i++)
            run_line[i] = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [IVL_W-1:0] val);
        if (idx < REG_ACTIVE_MASK)
            interval_ms[idx] = val;
        else if (idx == REG_ACTIVE_MASK)
            enabled_slots = val[MASK_W-1:0];
    endfunction

    function automatic report_t slot_report(logic [KIND_W-1:0] k, int s, bit with_stats);
        report_t r = '0;
        r.kind = k;
        r.slot = SLOT_W'(s);
        if (with_stats) begin
            r.runs = runs[s];
            r.total = busy_total[s];
            r.lo = busy_min[s];
            r.hi = busy_max[s];
        end
        return r;
    endfunction

    // A dispatch bumps the run count and pushes the due time one interval past now.
    function automatic void run_slot(int s, logic [TIME_W-1:0] t);
        if (runs[s] != '1)
            runs[s] = runs[s] + 1'b1;
        in_queue[s] = 1'b0;
        next_due[s] = t + 32'(interval_ms[s]) * 32'(MS_TO_US);
    endfunction

    // Update the expected state for one accepted word and queue the results it causes.
    function automatic void advance_scheduler(command_t c);
        report_t batch[$];
        logic [TIME_W-1:0] diff;
        logic [TOTAL_W:0] sum;
        int p;
        case (c.func)
            FUNC_START: begin
                line_head = '0;
                line_fill = '0;
                for (int i = 0; i < MAX_SLOTS; i++)
                    in_queue[i] = 1'b0;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (enabled_slots[i]) begin
                        run_slot(i, c.now);
                        batch.insert(batch.size(), slot_report(KIND_DISPATCH, i, 1'b1));
                    end
                end
                if (batch.size() == 0)
                    batch.insert(batch.size(), slot_report(KIND_NONE, 0, 1'b0));
            end
            FUNC_PROCESS: begin
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (enabled_slots[i] && !in_queue[i]) begin
                        diff = next_due[i] - c.now;
                        if ((diff == '0 || diff[TIME_W-1]) && line_fill < FIFO_DEPTH) begin
                            run_line[FIFO_AW'(line_head + line_fill)] = SLOT_W'(i);
                            line_fill = line_fill + 1'b1;
                            in_queue[i] = 1'b1;
                        end
                    end
                end
                if (line_fill > 0) begin
                    p = run_line[line_head];
                    line_head = line_head + 1'b1;
                    line_fill = line_fill - 1'b1;
                    run_slot(p, c.now);
                    batch.insert(batch.size(), slot_report(KIND_DISPATCH, p, 1'b1));
                end else begin
                    batch.insert(batch.size(), slot_report(KIND_NONE, 0, 1'b0));
                end
            end
            FUNC_DONE: begin
                p = c.slot;
                sum = {1'b0, busy_total[p]} + c.dur;
                busy_total[p] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                if (c.dur < busy_min[p])
                    busy_min[p] = c.dur;
                if (c.dur > busy_max[p])
                    busy_max[p] = c.dur;
                batch.insert(batch.size(), slot_report(KIND_STATS, p, 1'b1));
            end
            default: ;
        endcase
        if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                awaited_reports.insert(awaited_reports.size(), batch[i]);
        end
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: presents queued words on the command port and holds each until accepted.
    always @(posedge clk) begin
        command_t nxt;
        if (rst_n) begin
            if (start && !busy) begin
                advance_scheduler(word_on_port);
                idle_left = pick_gap();
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (command_queue.size() > 0 &&
                             !(command_queue[0].drain_first && awaited_reports.size() > 0)) begin
                    nxt = command_queue[0];
                    command_queue.delete(0);
                    word_on_port = nxt;
                    start <= 1'b1;
                    func <= nxt.func;
                    now_us <= nxt.now;
                    slot <= nxt.slot;
                    duration_us <= nxt.dur;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string label, logic [TOTAL_W-1:0] want,
                                        logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: every strobed word is matched against the oldest expected one.
    always @(posedge clk) begin
        report_t want;
        if (rst_n && strobe) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t ns: unexpected word kind %0d slot %0d, expected none",
                         $time, kind, slot_out);
                mismatches++;
            end else begin
                want = awaited_reports[0];
                awaited_reports.delete(0);
                check_field("kind", want.kind, kind);
                check_field("slot_out", want.slot, slot_out);
                check_field("run_count", want.runs, run_count);
                check_field("total_time", want.total, total_time);
                check_field("shortest", want.lo, shortest);
                check_field("longest", want.hi, longest);
                check_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic void queue_cmd(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] t,
                                      logic [SLOT_W-1:0] s, logic [DUR_W-1:0] d, bit drain);
        command_t c;
        c.func = f;
        c.now = t;
        c.slot = s;
        c.dur = d;
        c.drain_first = drain;
        command_queue.insert(command_queue.size(), c);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        if ($urandom_range(0, 9) < 6)
            return DUR_W'($urandom_range(0, 150000));
        return DUR_W'($urandom);
    endfunction

    function automatic logic [IVL_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return IVL_W'($urandom_range(0, 3));
        if (r < 85)
            return IVL_W'($urandom_range(4, 100));
        return IVL_W'($urandom);
    endfunction

    // Wait until the block has gone quiet with nothing left to deliver.
    task automatic settle();
        do
            @(posedge clk);
        while (command_queue.size() != 0 || start || busy || awaited_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [IVL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [TIME_W-1:0] clock_us;
        int pick;
        clear_schedule();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing registered: start and process both report idle; stats at the extremes.
        queue_cmd(FUNC_START, '0, '0, '0, 1'b0);
        queue_cmd(FUNC_PROCESS, '0, '1, '1, 1'b0);
        queue_cmd(FUNC_DONE, '1, 2'd0, '0, 1'b0);
        queue_cmd(FUNC_DONE, 32'h5555_AAAA, 2'd3, '1, 1'b0);
        queue_cmd(FUNC_SPARE, '1, '1, '1, 1'b0);
        queue_cmd(FUNC_PROCESS, '1, 2'd2, 24'h00_F00F, 1'b0);
        settle();

        // All four slots with the shortest and longest intervals; build up a queue.
        set_reg(REG_INTERVAL_0, 16'd0);
        set_reg(CFG_IDX_W'(REG_INTERVAL_0 + 1), 16'hFFFF);
        set_reg(CFG_IDX_W'(REG_INTERVAL_0 + 2), 16'd1);
        set_reg(CFG_IDX_W'(REG_INTERVAL_0 + 3), 16'd2);
        set_reg(REG_ACTIVE_MASK, 16'h000F);
        set_reg(REG_SPARE, 16'hFFFF);
        queue_cmd(FUNC_START, 32'd1000, 2'd1, 24'd7, 1'b0);
        queue_cmd(FUNC_PROCESS, 32'd3000, 2'd0, 24'd0, 1'b0);
        queue_cmd(FUNC_PROCESS, 32'd3000, 2'd0, 24'd0, 1'b1);
        queue_cmd(FUNC_DONE, 32'd3000, 2'd1, 24'd5, 1'b0);
        queue_cmd(FUNC_DONE, 32'd3000, 2'd1, 24'd200000, 1'b0);
        queue_cmd(FUNC_DONE, 32'd3000, 2'd0, 24'd0, 1'b0);
        queue_cmd(FUNC_DONE, 32'd3000, 2'd3, '1, 1'b0);
        settle();

        // Slots still waiting in the queue lose their active bit; a restart flushes the rest.
        set_reg(REG_ACTIVE_MASK, 16'h0001);
        queue_cmd(FUNC_PROCESS, 32'd3000, 2'd0, 24'd0, 1'b0);
        queue_cmd(FUNC_START, 32'd5, 2'd0, 24'd0, 1'b0);
        queue_cmd(FUNC_PROCESS, 32'd5, 2'd0, 24'd0, 1'b0);
        queue_cmd(FUNC_PROCESS, 32'h8000_0004, 2'd0, 24'd0, 1'b0);

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            for (int i = 0; i < MAX_SLOTS; i++)
                set_reg(CFG_IDX_W'(REG_INTERVAL_0 + i), pick_interval());
            if (ph == 0)
                set_reg(REG_ACTIVE_MASK, IVL_W'($urandom) | 16'h000F);
            else if (ph == 1)
                set_reg(REG_ACTIVE_MASK, IVL_W'($urandom) & 16'hFFF0);
            else
                set_reg(REG_ACTIVE_MASK, IVL_W'($urandom));
            gaps_on = (ph != 2);
            if (ph == 3)
                clock_us = 32'hFFFF_FF00 - $urandom_range(0, 5000);
            else
                clock_us = $urandom;
            queue_cmd(FUNC_START, clock_us, SLOT_W'($urandom), pick_duration(), 1'b0);
            repeat (36) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    if ($urandom_range(0, 9) != 0)
                        clock_us = clock_us + $urandom_range(0, 2500);
                    else if ($urandom_range(0, 2) != 0)
                        clock_us = clock_us + $urandom_range(0, 70000000);
                    else
                        clock_us = clock_us + $urandom;
                    queue_cmd(FUNC_PROCESS, clock_us, SLOT_W'($urandom), DUR_W'($urandom),
                              $urandom_range(0, 24) == 0);
                end else if (pick < 80) begin
                    queue_cmd(FUNC_DONE, $urandom, SLOT_W'($urandom), pick_duration(),
                              $urandom_range(0, 24) == 0);
                end else if (pick < 86) begin
                    queue_cmd(FUNC_START, clock_us, SLOT_W'($urandom), DUR_W'($urandom), 1'b0);
                end else if (pick < 91) begin
                    queue_cmd(FUNC_SPARE, $urandom, SLOT_W'($urandom), DUR_W'($urandom), 1'b0);
                end else begin
                    // Noise: any code at an unrelated time.
                    queue_cmd(FUNC_W'($urandom), $urandom, SLOT_W'($urandom), DUR_W'($urandom),
                              1'b0);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
